### sv/lpaf_pkg.sv
`timescale 1ns / 1ps
// Package for the layer plane average fold block: register map, fixed field widths and types.
// No dependencies; the front end, back end and top level refer to it by scoped names.
package lpaf_pkg;

    // Configuration port shape.
    localparam int CFG_IDX_BITS  = 4;
    localparam int CFG_DATA_BITS = 11;

    // Fixed widths of the configuration registers and of the layer number output.
    localparam int CELL_REG_BITS = 11;
    localparam int SEG_REG_BITS  = 7;
    localparam int SEG_REGS      = 4;
    localparam int IDX_OUT_BITS  = 6;

    // Register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_CELLS_X     = 4'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CELLS_Z     = 4'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LAYERS_SEG0 = 4'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LAYERS_SEG1 = 4'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LAYERS_SEG2 = 4'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LAYERS_SEG3 = 4'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FOLD_ENABLE = 4'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ANTISYM     = 4'd7;

    // Fold controls handed to the back end.
    typedef struct packed {
        logic fold_enable;
        logic antisymmetric;
    } t_fold_ctl;

    typedef logic [SEG_REGS-1:0][SEG_REG_BITS-1:0] t_seg_layers;

endpackage

### sv/lpaf_ram.sv
`timescale 1ns / 1ps
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module lpaf_ram #(
    parameter int WIDTH = 52,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port; a read at the written address returns the old word.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/lpaf_fifo.sv
`timescale 1ns / 1ps
// Small register queue with push/full and pop/empty sides.
// No dependencies; used for the work queue and for the result queue.
module lpaf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_data [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_data[r_rd_ptr];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // Storage words need no reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_data[r_wr_ptr] <= i_data;
        end
    end

endmodule

### sv/lpaf_front.sv
`timescale 1ns / 1ps
// Front end: plans the layer layout of the segments and walks the x, layer and z counters.
// Depends on lpaf_pkg; tags every accepted cell with its layer and the end of the pass.
module lpaf_front #(
    parameter int MAX_LAYERS  = 64,
    parameter int MAX_CELLS_X = 1024,
    parameter int MAX_CELLS_Z = 1024,
    parameter int SEGMENTS    = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_clear,
    input  lpaf_pkg::t_seg_layers            i_seg_layers,
    input  logic [$clog2(MAX_CELLS_X+1)-1:0] i_nx,
    input  logic [$clog2(MAX_CELLS_Z+1)-1:0] i_nz,
    input  logic                             i_step,
    output logic [$clog2(MAX_LAYERS)-1:0]    o_idx,
    output logic                             o_last,
    output logic [$clog2(MAX_LAYERS+1)-1:0]  o_total
);

    localparam int LW  = $clog2(MAX_LAYERS + 1);
    localparam int IW  = $clog2(MAX_LAYERS);
    localparam int XW  = $clog2(MAX_CELLS_X + 1);
    localparam int ZW  = $clog2(MAX_CELLS_Z + 1);
    localparam int SGW = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
    localparam int CW  = (LW > lpaf_pkg::SEG_REG_BITS) ? LW : lpaf_pkg::SEG_REG_BITS;

    logic [SEGMENTS-1:0][LW-1:0] eff;
    logic [LW-1:0]  total;
    logic [CW-1:0]  remain;
    logic [CW-1:0]  take;
    logic [CW-1:0]  tot_w;
    logic [SGW-1:0] cur;
    logic           found;
    logic           more;
    logic [LW-1:0]  eff_cur;
    logic [LW-1:0]  idx_full;
    logic           x_last;
    logic           loc_last;
    logic           z_last;
    logic           pass_end;

    logic [XW-1:0]  r_x;
    logic [LW-1:0]  r_loc;
    logic [ZW-1:0]  r_z;
    logic [SGW-1:0] r_seg;
    logic [LW-1:0]  r_base;

    // Layers per segment, cut so that the total stays within the layer store.
    always_comb begin
        remain = CW'(MAX_LAYERS);
        tot_w  = '0;
        eff    = '0;
        for (int s = 0; s < SEGMENTS; s++) begin
            take = '0;
            if (s < lpaf_pkg::SEG_REGS) begin
                take = CW'(i_seg_layers[s % lpaf_pkg::SEG_REGS]);
            end
            if (take > remain) begin
                take = remain;
            end
            eff[s] = LW'(take);
            remain = remain - take;
            tot_w  = tot_w + take;
        end
        if (tot_w == '0) begin
            eff[0] = LW'(1);
            tot_w  = CW'(1);
        end
        total = LW'(tot_w);
    end

    // Current segment is the first non-empty one at or after the segment pointer.
    always_comb begin
        cur   = '0;
        found = 1'b0;
        more  = 1'b0;
        for (int s = 0; s < SEGMENTS; s++) begin
            if (!found && (s >= int'(r_seg)) && (eff[s] != '0)) begin
                cur   = SGW'(s);
                found = 1'b1;
            end
        end
        for (int s = 0; s < SEGMENTS; s++) begin
            if ((s > int'(cur)) && (eff[s] != '0)) begin
                more = 1'b1;
            end
        end
        eff_cur = eff[cur];
    end

    assign x_last   = (r_x + XW'(1)) == i_nx;
    assign loc_last = (r_loc + LW'(1)) == eff_cur;
    assign z_last   = (r_z + ZW'(1)) == i_nz;
    assign pass_end = x_last && loc_last && z_last && !more;
    assign idx_full = r_base + r_loc;

    assign o_idx   = idx_full[IW-1:0];
    assign o_last  = pass_end;
    assign o_total = total;

    // Position counters: x fastest, then the local layer, then z, then the segment.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear || (i_step && pass_end)) begin
            r_x    <= '0;
            r_loc  <= '0;
            r_z    <= '0;
            r_seg  <= '0;
            r_base <= '0;
        end else if (i_step) begin
            if (x_last && loc_last && z_last) begin
                r_seg <= cur + SGW'(1);
            end else begin
                r_seg <= cur;
            end
            if (!x_last) begin
                r_x <= r_x + XW'(1);
            end else begin
                r_x <= '0;
                if (!loc_last) begin
                    r_loc <= r_loc + LW'(1);
                end else begin
                    r_loc <= '0;
                    if (!z_last) begin
                        r_z <= r_z + ZW'(1);
                    end else begin
                        r_z    <= '0;
                        r_base <= r_base + eff_cur;
                    end
                end
            end
        end
    end

endmodule

### sv/lpaf_back.sv
`timescale 1ns / 1ps
// Back end: accumulates layer sums in RAM, then divides, folds if enabled and queues the profile.
// Depends on lpaf_pkg and lpaf_ram.
module lpaf_back #(
    parameter int MAX_LAYERS  = 64,
    parameter int MAX_CELLS_X = 1024,
    parameter int MAX_CELLS_Z = 1024,
    parameter int VALUE_BITS  = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_clear,
    input  lpaf_pkg::t_fold_ctl                  i_ctl,
    input  logic [$clog2(MAX_LAYERS+1)-1:0]      i_total,
    input  logic [$clog2(MAX_CELLS_X+1)-1:0]     i_nx,
    input  logic [$clog2(MAX_CELLS_Z+1)-1:0]     i_nz,
    input  logic                                 i_q_empty,
    input  logic [$clog2(MAX_LAYERS)-1:0]        i_q_idx,
    input  logic [VALUE_BITS-1:0]                i_q_value,
    input  logic                                 i_q_last,
    output logic                                 o_q_pop,
    input  logic                                 i_res_full,
    output logic                                 o_res_push,
    output logic [lpaf_pkg::IDX_OUT_BITS-1:0]    o_res_idx,
    output logic [VALUE_BITS-1:0]                o_res_mean,
    output logic                                 o_res_last
);

    localparam int LW  = $clog2(MAX_LAYERS + 1);
    localparam int IW  = $clog2(MAX_LAYERS);
    localparam int XW  = $clog2(MAX_CELLS_X + 1);
    localparam int ZW  = $clog2(MAX_CELLS_Z + 1);
    localparam int CB  = XW + ZW;
    localparam int SBF = VALUE_BITS + $clog2(MAX_CELLS_X) + $clog2(MAX_CELLS_Z);
    localparam int SB  = (SBF > 64) ? 64 : SBF;
    localparam int SW  = $clog2(SB);

    localparam logic [2:0] S_ACC  = 3'd0;
    localparam logic [2:0] S_RDA  = 3'd1;
    localparam logic [2:0] S_RDB  = 3'd2;
    localparam logic [2:0] S_DIVA = 3'd3;
    localparam logic [2:0] S_DIVB = 3'd4;
    localparam logic [2:0] S_PUSH = 3'd5;

    logic [2:0]             r_state;
    logic [2:0]             n_state;
    logic [MAX_LAYERS-1:0]  r_valid;
    logic                   r_s1_vld;
    logic [IW-1:0]          r_s1_idx;
    logic [VALUE_BITS-1:0]  r_s1_val;
    logic                   r_s1_last;
    logic                   r_wr_vld;
    logic [IW-1:0]          r_wr_idx;
    logic [SB-1:0]          r_wr_sum;
    logic [IW-1:0]          r_j;
    logic [CB-1:0]          r_cnt;
    logic [SB-1:0]          r_bsum;
    logic [CB-1:0]          r_rem;
    logic [SB-1:0]          r_quo;
    logic                   r_neg;
    logic [SW-1:0]          r_step;
    logic [SB-1:0]          r_ma;
    logic [SB-1:0]          r_mb;

    logic [IW-1:0]          raddr;
    logic [SB-1:0]          ram_q;
    logic                   ram_we;
    logic [SB-1:0]          old_sum;
    logic [SB-1:0]          new_sum;
    logic [LW-1:0]          res_count;
    logic [LW-1:0]          mirror_full;
    logic [IW-1:0]          mirror;
    logic                   j_last;
    logic                   s1_end;
    logic                   pass_done;
    logic                   ld_div;
    logic [SB-1:0]          ld_num;
    logic [SB-1:0]          ld_mag;
    logic [CB:0]            rem_sh;
    logic                   ge;
    logic [CB:0]            rem_sub;
    logic [SB-1:0]          quo_n;
    logic [SB-1:0]          div_res;
    logic                   div_done;
    logic signed [SB:0]     fold_sum;
    logic signed [SB:0]     fold_half;
    logic [IW+lpaf_pkg::IDX_OUT_BITS-1:0] j_ext;

    // Layer sum store.
    lpaf_ram #(
        .WIDTH (SB),
        .DEPTH (MAX_LAYERS)
    ) u_sums (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s1_idx),
        .i_wdata (new_sum),
        .i_raddr (raddr),
        .o_rdata (ram_q)
    );

    // Profile length and mirror layer of the current result.
    assign res_count   = i_ctl.fold_enable ? (i_total >> 1) : i_total;
    assign mirror_full = i_total - LW'(1) - LW'(r_j);
    assign mirror      = mirror_full[IW-1:0];
    assign j_last      = (LW'(r_j) + LW'(1)) == res_count;

    // Accumulate path: the previous write is forwarded past the registered read.
    assign o_q_pop = (r_state == S_ACC) && !i_q_empty && !(r_s1_vld && r_s1_last) && !i_clear;
    assign ram_we  = (r_state == S_ACC) && r_s1_vld;
    assign s1_end  = ram_we && r_s1_last;
    assign old_sum = (r_wr_vld && (r_wr_idx == r_s1_idx)) ? r_wr_sum
                   : (r_valid[r_s1_idx] ? ram_q : '0);
    assign new_sum = old_sum + SB'($signed(r_s1_val));

    always_comb begin
        case (r_state)
            S_ACC:   raddr = i_q_idx;
            S_RDA:   raddr = r_j;
            default: raddr = mirror;
        endcase
    end

    // Divider load: layer j from the read data, its mirror from the held word.
    assign ld_div = (r_state == S_RDB) || (div_done && (r_state == S_DIVA) && i_ctl.fold_enable);
    assign ld_num = (r_state == S_RDB) ? (r_valid[r_j] ? ram_q : '0) : r_bsum;
    assign ld_mag = ld_num[SB-1] ? (~ld_num + SB'(1)) : ld_num;

    // One quotient bit per cycle, restoring division of the magnitude.
    assign rem_sh   = {r_rem, r_quo[SB-1]};
    assign ge       = rem_sh >= {1'b0, r_cnt};
    assign rem_sub  = ge ? (rem_sh - {1'b0, r_cnt}) : rem_sh;
    assign quo_n    = {r_quo[SB-2:0], ge};
    assign div_res  = r_neg ? (~quo_n + SB'(1)) : quo_n;
    assign div_done = (r_step == SW'(SB - 1));

    // Fold as half sum or half difference, rounding toward zero.
    assign fold_sum  = i_ctl.antisymmetric
                     ? ($signed({r_ma[SB-1], r_ma}) - $signed({r_mb[SB-1], r_mb}))
                     : ($signed({r_ma[SB-1], r_ma}) + $signed({r_mb[SB-1], r_mb}));
    assign fold_half = (fold_sum + $signed({{SB{1'b0}}, fold_sum[SB]})) >>> 1;

    assign j_ext      = {{lpaf_pkg::IDX_OUT_BITS{1'b0}}, r_j};
    assign o_res_push = (r_state == S_PUSH) && !i_res_full;
    assign o_res_idx  = j_ext[lpaf_pkg::IDX_OUT_BITS-1:0];
    assign o_res_mean = i_ctl.fold_enable ? fold_half[VALUE_BITS-1:0] : r_ma[VALUE_BITS-1:0];
    assign o_res_last = j_last;

    assign pass_done = (s1_end && (res_count == '0)) || (o_res_push && j_last);

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_ACC: begin
                if (s1_end && (res_count != '0)) begin
                    n_state = S_RDA;
                end
            end
            S_RDA:  n_state = S_RDB;
            S_RDB:  n_state = S_DIVA;
            S_DIVA: begin
                if (div_done) begin
                    n_state = i_ctl.fold_enable ? S_DIVB : S_PUSH;
                end
            end
            S_DIVB: begin
                if (div_done) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (o_res_push) begin
                    n_state = j_last ? S_ACC : S_RDA;
                end
            end
            default: n_state = S_ACC;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_state  <= S_ACC;
            r_valid  <= '0;
            r_s1_vld <= 1'b0;
            r_wr_vld <= 1'b0;
            r_j      <= '0;
        end else begin
            r_state  <= n_state;
            r_s1_vld <= o_q_pop;
            r_wr_vld <= ram_we;
            if (pass_done) begin
                r_valid <= '0;
            end else if (ram_we) begin
                r_valid[r_s1_idx] <= 1'b1;
            end
            if (s1_end) begin
                r_j <= '0;
            end else if (o_res_push) begin
                r_j <= r_j + IW'(1);
            end
        end
    end

    // Data path registers.
    always_ff @(posedge i_clk) begin
        r_cnt <= CB'(i_nx) * CB'(i_nz);
        if (o_q_pop) begin
            r_s1_idx  <= i_q_idx;
            r_s1_val  <= i_q_value;
            r_s1_last <= i_q_last;
        end
        if (ram_we) begin
            r_wr_idx <= r_s1_idx;
            r_wr_sum <= new_sum;
        end
        if ((r_state == S_DIVA) && (r_step == '0)) begin
            r_bsum <= r_valid[mirror] ? ram_q : '0;
        end
        if (ld_div) begin
            r_neg  <= ld_num[SB-1];
            r_quo  <= ld_mag;
            r_rem  <= '0;
            r_step <= '0;
        end else if ((r_state == S_DIVA) || (r_state == S_DIVB)) begin
            r_quo  <= quo_n;
            r_rem  <= rem_sub[CB-1:0];
            r_step <= r_step + SW'(1);
        end
        if (div_done && (r_state == S_DIVA)) begin
            r_ma <= div_res;
        end
        if (div_done && (r_state == S_DIVB)) begin
            r_mb <= div_res;
        end
    end

`ifndef SYNTHESIS
    // Work is taken from the queue only while accumulating.
    a_pop_in_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (r_state == S_ACC))
        else $error("work word taken while the profile is being emitted");

    // Results leave only from the push state.
    a_push_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> (r_state == S_PUSH))
        else $error("result word pushed outside the push state");

    // The cell that ends a pass is followed by no further work until the store is cleared.
    a_end_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n || i_clear)
        s1_end |=> !r_s1_vld)
        else $error("accumulation continued past the end of a pass");

    // A finished division leaves the divider state.
    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n || i_clear)
        ((r_state == S_DIVB) && div_done) |=> (r_state == S_PUSH))
        else $error("divider did not hand its result on");
`endif

endmodule

### sv/layer_plane_average_fold.sv
`timescale 1ns / 1ps
// A cell passes the work queue and a stage register before it is added to its layer sum;
// one cell per cycle while accumulating. After the cell that ends a pass, each result is
// divided by the bit-serial divider (SB = 52 sum bits at the default sizes), twice with folding.
// Cells of the next pass are taken into the work queue meanwhile and wait there.
// Reset is synchronous and active low: registers return to their defaults, sums read as zero.
// Top level: configuration registers, work and result queues, front and back ends.
module layer_plane_average_fold #(
    parameter int MAX_LAYERS  = 64,
    parameter int MAX_CELLS_X = 1024,
    parameter int MAX_CELLS_Z = 1024,
    parameter int SEGMENTS    = 4,
    parameter int VALUE_BITS  = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [lpaf_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [lpaf_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    input  logic                                 push,
    output logic                                 full,
    input  logic [VALUE_BITS-1:0]                i_cell_value,
    input  logic                                 pop,
    output logic                                 empty,
    output logic [lpaf_pkg::IDX_OUT_BITS-1:0]    o_layer_index,
    output logic [VALUE_BITS-1:0]                o_layer_mean,
    output logic                                 o_last_layer
);

    localparam int LW = $clog2(MAX_LAYERS + 1);
    localparam int IW = $clog2(MAX_LAYERS);
    localparam int XW = $clog2(MAX_CELLS_X + 1);
    localparam int ZW = $clog2(MAX_CELLS_Z + 1);
    localparam int QW = IW + VALUE_BITS + 1;
    localparam int RW = lpaf_pkg::IDX_OUT_BITS + VALUE_BITS + 1;

    logic [lpaf_pkg::CELL_REG_BITS-1:0] r_cells_x;
    logic [lpaf_pkg::CELL_REG_BITS-1:0] r_cells_z;
    lpaf_pkg::t_seg_layers              r_seg;
    lpaf_pkg::t_fold_ctl                r_ctl;

    logic           cfg_clear;
    logic           step;
    logic [XW-1:0]  nx;
    logic [ZW-1:0]  nz;
    logic [IW-1:0]  f_idx;
    logic           f_last;
    logic [LW-1:0]  total;
    logic           q_empty;
    logic [QW-1:0]  q_data;
    logic           q_pop;
    logic           res_full;
    logic           res_push;
    logic [lpaf_pkg::IDX_OUT_BITS-1:0] res_idx;
    logic [VALUE_BITS-1:0] res_mean;
    logic           res_last;
    logic [RW-1:0]  res_word;

    // Configuration registers; a write to any known register restarts the pass.
    assign cfg_clear = i_cfg_we && (i_cfg_idx <= lpaf_pkg::CFG_ANTISYM);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cells_x <= lpaf_pkg::CELL_REG_BITS'(1);
            r_cells_z <= lpaf_pkg::CELL_REG_BITS'(1);
            // Segment 0 holds one layer, the other segments none.
            r_seg     <= lpaf_pkg::t_seg_layers'(1);
            r_ctl     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lpaf_pkg::CFG_CELLS_X:     r_cells_x <= i_cfg_data;
                lpaf_pkg::CFG_CELLS_Z:     r_cells_z <= i_cfg_data;
                lpaf_pkg::CFG_LAYERS_SEG0: r_seg[0] <= i_cfg_data[lpaf_pkg::SEG_REG_BITS-1:0];
                lpaf_pkg::CFG_LAYERS_SEG1: r_seg[1] <= i_cfg_data[lpaf_pkg::SEG_REG_BITS-1:0];
                lpaf_pkg::CFG_LAYERS_SEG2: r_seg[2] <= i_cfg_data[lpaf_pkg::SEG_REG_BITS-1:0];
                lpaf_pkg::CFG_LAYERS_SEG3: r_seg[3] <= i_cfg_data[lpaf_pkg::SEG_REG_BITS-1:0];
                lpaf_pkg::CFG_FOLD_ENABLE: r_ctl.fold_enable <= i_cfg_data[0];
                lpaf_pkg::CFG_ANTISYM:     r_ctl.antisymmetric <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Cell counts: zero acts as one, oversize acts as the maximum.
    always_comb begin
        if (r_cells_x == '0) begin
            nx = XW'(1);
        end else if (int'(r_cells_x) > MAX_CELLS_X) begin
            nx = XW'(MAX_CELLS_X);
        end else begin
            nx = XW'(r_cells_x);
        end
        if (r_cells_z == '0) begin
            nz = ZW'(1);
        end else if (int'(r_cells_z) > MAX_CELLS_Z) begin
            nz = ZW'(MAX_CELLS_Z);
        end else begin
            nz = ZW'(r_cells_z);
        end
    end

    assign step = push && !full;

    // Front end: layer classification of each accepted cell.
    lpaf_front #(
        .MAX_LAYERS  (MAX_LAYERS),
        .MAX_CELLS_X (MAX_CELLS_X),
        .MAX_CELLS_Z (MAX_CELLS_Z),
        .SEGMENTS    (SEGMENTS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clear      (cfg_clear),
        .i_seg_layers (r_seg),
        .i_nx         (nx),
        .i_nz         (nz),
        .i_step       (step),
        .o_idx        (f_idx),
        .o_last       (f_last),
        .o_total      (total)
    );

    // Work queue between the two ends.
    lpaf_fifo #(
        .WIDTH (QW),
        .DEPTH (2)
    ) u_work_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (step),
        .i_data  ({f_idx, i_cell_value, f_last}),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_empty (q_empty)
    );

    // Back end: accumulation, division and folding.
    lpaf_back #(
        .MAX_LAYERS  (MAX_LAYERS),
        .MAX_CELLS_X (MAX_CELLS_X),
        .MAX_CELLS_Z (MAX_CELLS_Z),
        .VALUE_BITS  (VALUE_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (cfg_clear),
        .i_ctl      (r_ctl),
        .i_total    (total),
        .i_nx       (nx),
        .i_nz       (nz),
        .i_q_empty  (q_empty),
        .i_q_idx    (q_data[QW-1:VALUE_BITS+1]),
        .i_q_value  (q_data[VALUE_BITS:1]),
        .i_q_last   (q_data[0]),
        .o_q_pop    (q_pop),
        .i_res_full (res_full),
        .o_res_push (res_push),
        .o_res_idx  (res_idx),
        .o_res_mean (res_mean),
        .o_res_last (res_last)
    );

    // Result queue towards the consumer.
    lpaf_fifo #(
        .WIDTH (RW),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  ({res_idx, res_mean, res_last}),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_word),
        .o_empty (empty)
    );

    assign o_layer_index = res_word[RW-1:VALUE_BITS+1];
    assign o_layer_mean  = res_word[VALUE_BITS:1];
    assign o_last_layer  = res_word[0];

endmodule
